[hdl/fpa_pkg.sv]
// Shared types and constants for the fixed-point ALU.
// Depends on nothing; used by fixed_point_alu and its testbench.
`default_nettype none

package fpa_pkg;

   // Port widths of the request and response fields
   localparam int FIELD_BITS = 32;
   localparam int CMD_BITS   = 3;

   // Command codes; six and seven are unused and yield a zero result
   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_MIN = 3'd4,
      CMD_MAX = 3'd5
   } cmd_type;

   // Per-item control that rides along the pipeline with the data
   typedef struct packed {
      cmd_type cmd;
      logic    less;
      logic    equal;
      logic    greater;
      logic    dbz;
      logic    neg_q;
   } ctl_type;

endpackage

`default_nettype wire

[hdl/fpa_div_pipe.sv]
// Pipelined unsigned restoring divider with a sideband that travels along.
// Two quotient bits per register stage; each stage stalls on its own.
// Depends on nothing outside this file.
`default_nettype none

module fpa_div_pipe #(
   parameter int NUM_BITS  = 40,
   parameter int DEN_BITS  = 32,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [NUM_BITS-1:0]  in_num,
   input  wire logic [DEN_BITS-1:0]  in_den,
   input  wire logic [SIDE_BITS-1:0] in_side,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [NUM_BITS-1:0]       out_quot,
   output logic [SIDE_BITS-1:0]      out_side
);

   localparam int Steps     = 2;
   localparam int NumStages = (NUM_BITS + Steps - 1) / Steps;

   logic                 vld_ff  [NumStages];
   logic [DEN_BITS-1:0]  rem_ff  [NumStages];
   logic [NUM_BITS-1:0]  nq_ff   [NumStages];
   logic [DEN_BITS-1:0]  den_ff  [NumStages];
   logic [SIDE_BITS-1:0] side_ff [NumStages];
   logic [NumStages:0]   ld;

   // A stage loads when it is empty or its successor loads
   assign ld[NumStages] = out_ready;
   assign in_ready      = ld[0];

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      logic                 src_vld;
      logic [DEN_BITS-1:0]  src_rem;
      logic [NUM_BITS-1:0]  src_nq;
      logic [DEN_BITS-1:0]  src_den;
      logic [SIDE_BITS-1:0] src_side;
      logic [DEN_BITS-1:0]  rem_in;
      logic [NUM_BITS-1:0]  nq_in;
      logic [DEN_BITS:0]    shifted;
      logic [DEN_BITS:0]    trial;

      assign ld[s] = !vld_ff[s] || ld[s+1];

      if (s == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_nq   = in_num;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_nq   = nq_ff[s-1];
         assign src_den  = den_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      // Shift in one dividend bit per step, keep the difference when it does not borrow
      always_comb begin
         rem_in  = src_rem;
         nq_in   = src_nq;
         shifted = '0;
         trial   = '0;
         for (int j = 0; j < Steps; j++) begin
            if (s * Steps + j < NUM_BITS) begin
               shifted = {rem_in, nq_in[NUM_BITS-1]};
               trial   = shifted - {1'b0, src_den};
               nq_in   = {nq_in[NUM_BITS-2:0], 1'b0};
               if (shifted >= {1'b0, src_den}) begin
                  rem_in   = trial[DEN_BITS-1:0];
                  nq_in[0] = 1'b1;
               end else begin
                  rem_in = shifted[DEN_BITS-1:0];
               end
            end
         end
      end

      // Advance the stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ld[s]) begin
            vld_ff[s] <= src_vld;
         end
         if (ld[s]) begin
            rem_ff[s]  <= rem_in;
            nq_ff[s]   <= nq_in;
            den_ff[s]  <= src_den;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[NumStages-1];
   assign out_quot  = nq_ff[NumStages-1];
   assign out_side  = side_ff[NumStages-1];

endmodule

`default_nettype wire

[hdl/fixed_point_alu.sv]
// Fixed-point ALU top level: operand stages, multiplier, divider, output register.
// Depends on fpa_pkg and fpa_div_pipe.
//
// Signed Q(WORD_BITS-FRAC_BITS).FRAC_BITS ALU: add, subtract, multiply, divide,
// minimum and maximum on two raw operands, with compare flags, a wrap overflow
// flag and a divide-by-zero flag (which forces a zero result). Products and
// quotients are exact and truncate toward zero. The working word is WORD_BITS
// wide, capped at 32; operands come from their low word bits, the result is
// zero-extended to 32. One item is accepted every cycle while the response side
// does not stall; every command takes the same path, through stages A, B and C,
// the divider pipeline and the output register, from request transfer to
// response valid. The divider resolves two quotient bits per pipeline stage.
// Each stage holds on its own when the response side stalls, so bubbles close
// up and nothing is dropped or repeated.
`default_nettype none

module fixed_point_alu #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fpa_pkg::CMD_BITS-1:0]        req_command,
   input  wire logic signed [fpa_pkg::FIELD_BITS-1:0] req_operand_a,
   input  wire logic signed [fpa_pkg::FIELD_BITS-1:0] req_operand_b,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [fpa_pkg::FIELD_BITS-1:0]    rsp_result_raw,
   output logic                                     rsp_a_less,
   output logic                                     rsp_a_equal,
   output logic                                     rsp_a_greater,
   output logic                                     rsp_overflow,
   output logic                                     rsp_divide_by_zero
);

   localparam int WordEff  = (WORD_BITS < fpa_pkg::FIELD_BITS) ? WORD_BITS
                                                               : fpa_pkg::FIELD_BITS;
   localparam int ProdBits = 2 * WordEff;
   localparam int NumBits  = WordEff + FRAC_BITS;
   localparam int CtlBits  = $bits(fpa_pkg::ctl_type);
   localparam int SideBits = CtlBits + WordEff + 1;
   localparam logic [ProdBits-1:0] RoundAdj = {{(ProdBits-FRAC_BITS){1'b0}},
                                               {FRAC_BITS{1'b1}}};
   localparam logic [NumBits-1:0]  HalfMag  = NumBits'(1) << (WordEff - 1);

   // Stage A: operand registers
   logic                        vld_a_ff;
   fpa_pkg::cmd_type            cmd_a_ff;
   logic signed [WordEff-1:0]   a_a_ff, b_a_ff;
   logic                        ld_a;

   // Stage B: product, simple results, divider operands
   logic                        vld_b_ff;
   fpa_pkg::ctl_type            ctl_b_ff, ctl_b_in;
   logic signed [ProdBits-1:0]  prod_b_ff, prod_b_in;
   logic [WordEff-1:0]          res_b_ff, res_b_in;
   logic                        ovf_b_ff, ovf_b_in;
   logic [NumBits-1:0]          num_b_ff, num_b_in;
   logic [WordEff-1:0]          den_b_ff, den_b_in;
   logic [WordEff:0]            sum_b, dif_b;
   logic [WordEff-1:0]          mag_a, mag_b;
   logic                        ld_b;

   // Stage C: truncated product merged in, feeds the divider
   logic                        vld_c_ff;
   fpa_pkg::ctl_type            ctl_c_ff;
   logic [WordEff-1:0]          res_c_ff, res_c_in;
   logic                        ovf_c_ff, ovf_c_in;
   logic [NumBits-1:0]          num_c_ff;
   logic [WordEff-1:0]          den_c_ff;
   logic [ProdBits-1:0]         prod_adj;
   logic signed [ProdBits-1:0]  mul_q;
   logic                        ld_c;

   // Divider and output stage
   logic                        div_in_ready;
   logic                        div_out_valid;
   logic [NumBits-1:0]          div_quot;
   logic [SideBits-1:0]         div_side;
   fpa_pkg::ctl_type            ctl_o;
   logic [WordEff-1:0]          res_o;
   logic                        ovf_o;
   logic [NumBits-1:0]          quot_s;
   logic                        quot_ovf;
   logic                        ld_o;

   logic                        rsp_valid_ff;
   logic [WordEff-1:0]          rsp_res_ff, rsp_res_in;
   logic                        rsp_less_ff, rsp_equal_ff, rsp_greater_ff;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        rsp_dbz_ff;

   // Load chain: a stage takes new data when empty or when its successor loads
   assign ld_o      = !rsp_valid_ff || rsp_ready;
   assign ld_c      = !vld_c_ff || div_in_ready;
   assign ld_b      = !vld_b_ff || ld_c;
   assign ld_a      = !vld_a_ff || ld_b;
   assign req_ready = ld_a;

   // Stage A: capture the transfer, keep the low working-word bits of each operand
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (ld_a) begin
         vld_a_ff <= req_valid;
      end
      if (ld_a) begin
         cmd_a_ff <= fpa_pkg::cmd_type'(req_command);
         a_a_ff   <= req_operand_a[WordEff-1:0];
         b_a_ff   <= req_operand_b[WordEff-1:0];
      end
   end

   // Stage B: compare, add/sub/min/max, multiply, divider operand prep
   always_comb begin
      sum_b     = {a_a_ff[WordEff-1], a_a_ff} + {b_a_ff[WordEff-1], b_a_ff};
      dif_b     = {a_a_ff[WordEff-1], a_a_ff} - {b_a_ff[WordEff-1], b_a_ff};
      prod_b_in = a_a_ff * b_a_ff;
      mag_a     = a_a_ff[WordEff-1] ? (~a_a_ff + 1'b1) : a_a_ff;
      mag_b     = b_a_ff[WordEff-1] ? (~b_a_ff + 1'b1) : b_a_ff;
      num_b_in  = {mag_a, {FRAC_BITS{1'b0}}};
      den_b_in  = mag_b;

      ctl_b_in.cmd     = cmd_a_ff;
      ctl_b_in.less    = a_a_ff < b_a_ff;
      ctl_b_in.equal   = a_a_ff == b_a_ff;
      ctl_b_in.greater = a_a_ff > b_a_ff;
      ctl_b_in.dbz     = (cmd_a_ff == fpa_pkg::CMD_DIV) && (b_a_ff == '0);
      ctl_b_in.neg_q   = a_a_ff[WordEff-1] ^ b_a_ff[WordEff-1];

      res_b_in = '0;
      ovf_b_in = 1'b0;
      case (cmd_a_ff)
         fpa_pkg::CMD_ADD: begin
            res_b_in = sum_b[WordEff-1:0];
            ovf_b_in = sum_b[WordEff] ^ sum_b[WordEff-1];
         end
         fpa_pkg::CMD_SUB: begin
            res_b_in = dif_b[WordEff-1:0];
            ovf_b_in = dif_b[WordEff] ^ dif_b[WordEff-1];
         end
         fpa_pkg::CMD_MIN: begin
            res_b_in = (b_a_ff < a_a_ff) ? b_a_ff : a_a_ff;
         end
         fpa_pkg::CMD_MAX: begin
            res_b_in = (b_a_ff > a_a_ff) ? b_a_ff : a_a_ff;
         end
         default: begin
            res_b_in = '0;
            ovf_b_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (ld_b) begin
         vld_b_ff <= vld_a_ff;
      end
      if (ld_b) begin
         ctl_b_ff  <= ctl_b_in;
         prod_b_ff <= prod_b_in;
         res_b_ff  <= res_b_in;
         ovf_b_ff  <= ovf_b_in;
         num_b_ff  <= num_b_in;
         den_b_ff  <= den_b_in;
      end
   end

   // Stage C: truncate the product toward zero, check it fits the word
   always_comb begin
      prod_adj = prod_b_ff + (prod_b_ff[ProdBits-1] ? RoundAdj : '0);
      mul_q    = signed'(prod_adj) >>> FRAC_BITS;
      if (ctl_b_ff.cmd == fpa_pkg::CMD_MUL) begin
         res_c_in = mul_q[WordEff-1:0];
         ovf_c_in = (mul_q[ProdBits-1:WordEff-1] != '0) &&
                    (mul_q[ProdBits-1:WordEff-1] != '1);
      end else begin
         res_c_in = res_b_ff;
         ovf_c_in = ovf_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (ld_c) begin
         vld_c_ff <= vld_b_ff;
      end
      if (ld_c) begin
         ctl_c_ff <= ctl_b_ff;
         res_c_ff <= res_c_in;
         ovf_c_ff <= ovf_c_in;
         num_c_ff <= num_b_ff;
         den_c_ff <= den_b_ff;
      end
   end

   fpa_div_pipe #(
      .NUM_BITS  (NumBits),
      .DEN_BITS  (WordEff),
      .SIDE_BITS (SideBits)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_c_ff),
      .in_ready  (div_in_ready),
      .in_num    (num_c_ff),
      .in_den    (den_c_ff),
      .in_side   ({ctl_c_ff, res_c_ff, ovf_c_ff}),
      .out_valid (div_out_valid),
      .out_ready (ld_o),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // Output stage: sign the quotient, range check, select the result
   always_comb begin
      ctl_o    = fpa_pkg::ctl_type'(div_side[SideBits-1 -: CtlBits]);
      res_o    = div_side[WordEff:1];
      ovf_o    = div_side[0];
      quot_s   = ctl_o.neg_q ? (~div_quot + 1'b1) : div_quot;
      quot_ovf = ctl_o.neg_q ? (div_quot > HalfMag) : (div_quot >= HalfMag);
      if (ctl_o.cmd == fpa_pkg::CMD_DIV) begin
         rsp_res_in = ctl_o.dbz ? '0 : quot_s[WordEff-1:0];
         rsp_ovf_in = !ctl_o.dbz && quot_ovf;
      end else begin
         rsp_res_in = res_o;
         rsp_ovf_in = ovf_o;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_o) begin
         rsp_valid_ff <= div_out_valid;
      end
      if (ld_o) begin
         rsp_res_ff     <= rsp_res_in;
         rsp_ovf_ff     <= rsp_ovf_in;
         rsp_less_ff    <= ctl_o.less;
         rsp_equal_ff   <= ctl_o.equal;
         rsp_greater_ff <= ctl_o.greater;
         rsp_dbz_ff     <= ctl_o.dbz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_raw     = fpa_pkg::FIELD_BITS'(rsp_res_ff);
   assign rsp_a_less         = rsp_less_ff;
   assign rsp_a_equal        = rsp_equal_ff;
   assign rsp_a_greater      = rsp_greater_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

   // Divide by zero always comes with a zero result and no overflow
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> (rsp_result_raw == '0) && !rsp_overflow)
      else $error("divide by zero response carries a result or overflow");

   // Exactly one compare flag describes the operands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not one-hot");

   // The zero-divisor mark is only raised for the divide command
   assert property (@(posedge clock) disable iff (reset)
      vld_c_ff && ctl_c_ff.dbz |-> (ctl_c_ff.cmd == fpa_pkg::CMD_DIV) &&
                                   (den_c_ff == '0))
      else $error("zero-divisor mark on a non-divide or nonzero divisor");

   // A held response blocks the output stage from loading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_ff))
      else $error("stalled response lost its result");

endmodule

`default_nettype wire

[tb/sv/fixed_point_alu_test.sv]
// Self-checking testbench for the fixed-point ALU: a directed table, then random traffic.
// Depends on fpa_pkg and fixed_point_alu, which uses fpa_div_pipe; it reads no input.
`timescale 1ns / 100ps

module fixed_point_alu_test;

   localparam int FIELD_BITS   = fpa_pkg::FIELD_BITS;
   localparam int CMD_BITS     = fpa_pkg::CMD_BITS;
   localparam int FRAC_BITS    = 8;
   localparam int WORD_BITS    = 32;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200_000;

   localparam longint FRAC_SCALE = longint'(1) << FRAC_BITS;
   localparam longint WORD_MAX   = (longint'(1) << (WORD_BITS - 1)) - 1;
   localparam longint WORD_MIN   = -(longint'(1) << (WORD_BITS - 1));

   localparam logic signed [FIELD_BITS-1:0] RAW_MAX = 32'sh7fff_ffff;
   localparam logic signed [FIELD_BITS-1:0] RAW_MIN = 32'sh8000_0000;
   localparam logic signed [FIELD_BITS-1:0] RAW_ONE = 32'sh0000_0100;

   // Command codes the package leaves unnamed; both must give a zero result
   localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] result_raw;
      logic                         a_less;
      logic                         a_equal;
      logic                         a_greater;
      logic                         overflow;
      logic                         divide_by_zero;
   } outcome_type;

   typedef struct {
      logic [CMD_BITS-1:0]          command;
      logic signed [FIELD_BITS-1:0] a;
      logic signed [FIELD_BITS-1:0] b;
      bit                           known;
      outcome_type                  want;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [CMD_BITS-1:0]          req_command = fpa_pkg::CMD_ADD;
   logic signed [FIELD_BITS-1:0] req_operand_a = '0;
   logic signed [FIELD_BITS-1:0] req_operand_b = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [FIELD_BITS-1:0] rsp_result_raw;
   logic                         rsp_a_less;
   logic                         rsp_a_equal;
   logic                         rsp_a_greater;
   logic                         rsp_overflow;
   logic                         rsp_divide_by_zero;

   outcome_type  pending_outcomes[$];
   stim_row_type directed_rows[$];
   int           sender_idle_pct = 35;
   int           receiver_idle_pct = 62;
   int           failures = 0;
   int           cycles_run = 0;

   fixed_point_alu #(
      .FRAC_BITS(FRAC_BITS),
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_raw     (rsp_result_raw),
      .rsp_a_less         (rsp_a_less),
      .rsp_a_equal        (rsp_a_equal),
      .rsp_a_greater      (rsp_a_greater),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Compute the exact result in 64 bits, then wrap it to the word
   function automatic outcome_type fixed_point_op(input logic [CMD_BITS-1:0] command,
                                                  input logic signed [FIELD_BITS-1:0] a,
                                                  input logic signed [FIELD_BITS-1:0] b);
      longint      x;
      longint      y;
      longint      exact;
      outcome_type r;
      r = '0;
      x = a;
      y = b;
      exact = 0;
      case (command)
         fpa_pkg::CMD_ADD: exact = x + y;
         fpa_pkg::CMD_SUB: exact = x - y;
         fpa_pkg::CMD_MUL: exact = (x * y) / FRAC_SCALE;
         fpa_pkg::CMD_DIV: begin
            if (y == 0) r.divide_by_zero = 1'b1;
            else exact = (x * FRAC_SCALE) / y;
         end
         fpa_pkg::CMD_MIN: exact = (y < x) ? y : x;
         fpa_pkg::CMD_MAX: exact = (y > x) ? y : x;
         default: exact = 0;
      endcase
      r.overflow   = (exact < WORD_MIN) || (exact > WORD_MAX);
      r.result_raw = exact[FIELD_BITS-1:0];
      r.a_less     = x < y;
      r.a_equal    = x == y;
      r.a_greater  = x > y;
      return r;
   endfunction

   function automatic stim_row_type open_row(input logic [CMD_BITS-1:0] command,
                                             input logic signed [FIELD_BITS-1:0] a,
                                             input logic signed [FIELD_BITS-1:0] b);
      stim_row_type row;
      row.command = command;
      row.a       = a;
      row.b       = b;
      row.known   = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [CMD_BITS-1:0] command,
                                              input logic signed [FIELD_BITS-1:0] a,
                                              input logic signed [FIELD_BITS-1:0] b,
                                              input logic signed [FIELD_BITS-1:0] result_raw,
                                              input logic lt, input logic eq, input logic gt,
                                              input logic ovf, input logic dbz);
      stim_row_type row;
      row = open_row(command, a, b);
      row.known               = 1'b1;
      row.want.result_raw     = result_raw;
      row.want.a_less         = lt;
      row.want.a_equal        = eq;
      row.want.a_greater      = gt;
      row.want.overflow       = ovf;
      row.want.divide_by_zero = dbz;
      return row;
   endfunction

   // Mix extremes, values near zero, moderate magnitudes and full-range words
   function automatic logic signed [FIELD_BITS-1:0] pick_operand();
      logic signed [FIELD_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0:       v = RAW_MIN;
               1:       v = RAW_MAX;
               2:       v = '0;
               3:       v = -1;
               4:       v = 1;
               5:       v = RAW_ONE;
               default: v = -RAW_ONE;
            endcase
         end
         1, 2:    v = $signed($urandom_range(0, 8191)) - 4096;
         3, 4:    v = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Hold one transfer until accepted, idling beforehand at the current rate
   task automatic send_item(input logic [CMD_BITS-1:0] command,
                            input logic signed [FIELD_BITS-1:0] a,
                            input logic signed [FIELD_BITS-1:0] b,
                            input outcome_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= command;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(want);
   endtask

   task automatic compare_field(input string field, input logic [FIELD_BITS-1:0] want,
                                input logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         failures++;
      end
   endtask

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Match each result transfer against the oldest expectation
   always @(posedge clock) begin : check_transfer
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with nothing expected: result_raw %h", rsp_result_raw);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("result_raw", want.result_raw, rsp_result_raw);
            compare_field("a_less", want.a_less, rsp_a_less);
            compare_field("a_equal", want.a_equal, rsp_a_equal);
            compare_field("a_greater", want.a_greater, rsp_a_greater);
            compare_field("overflow", want.overflow, rsp_overflow);
            compare_field("divide_by_zero", want.divide_by_zero, rsp_divide_by_zero);
         end
      end
   end

   // Abort a run that hangs
   always @(posedge clock) cycles_run <= cycles_run + 1;

   initial begin
      wait (cycles_run == CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [CMD_BITS-1:0]          command;
      logic signed [FIELD_BITS-1:0] a;
      logic signed [FIELD_BITS-1:0] b;
      int                           pick;
      outcome_type                  want;

      directed_rows = '{
         // Results that follow directly from the operands
         known_row(fpa_pkg::CMD_ADD, 0, 0, 0, 0, 1, 0, 0, 0),
         known_row(fpa_pkg::CMD_DIV, RAW_ONE, 0, 0, 0, 0, 1, 0, 1),
         known_row(fpa_pkg::CMD_DIV, 0, 0, 0, 0, 1, 0, 0, 1),
         known_row(fpa_pkg::CMD_ADD, RAW_MAX, 1, RAW_MIN, 0, 0, 1, 1, 0),
         known_row(fpa_pkg::CMD_SUB, RAW_MIN, 1, RAW_MAX, 1, 0, 0, 1, 0),
         known_row(fpa_pkg::CMD_ADD, RAW_MIN, RAW_MIN, 0, 0, 1, 0, 1, 0),
         known_row(CMD_SPARE_LO, 5, 5, 0, 0, 1, 0, 0, 0),
         known_row(CMD_SPARE_HI, RAW_MIN, RAW_MAX, 0, 1, 0, 0, 0, 0),
         known_row(fpa_pkg::CMD_MIN, RAW_MAX, RAW_MIN, RAW_MIN, 0, 0, 1, 0, 0),
         known_row(fpa_pkg::CMD_MAX, RAW_MAX, RAW_MIN, RAW_MAX, 0, 0, 1, 0, 0),
         known_row(fpa_pkg::CMD_MUL, RAW_ONE, RAW_ONE, RAW_ONE, 0, 1, 0, 0, 0),
         // Wraps, truncation toward zero and ties, left to the predictor
         open_row(fpa_pkg::CMD_SUB, RAW_MAX, RAW_MIN),
         open_row(fpa_pkg::CMD_SUB, 0, RAW_MIN),
         open_row(fpa_pkg::CMD_MUL, RAW_MAX, RAW_MAX),
         open_row(fpa_pkg::CMD_MUL, RAW_MIN, RAW_MIN),
         open_row(fpa_pkg::CMD_MUL, RAW_MIN, RAW_MAX),
         open_row(fpa_pkg::CMD_MUL, -1, 1),
         open_row(fpa_pkg::CMD_MUL, -32'sh180, 32'sh101),
         open_row(fpa_pkg::CMD_DIV, RAW_MIN, -1),
         open_row(fpa_pkg::CMD_DIV, RAW_MAX, 1),
         open_row(fpa_pkg::CMD_DIV, -1, 3),
         open_row(fpa_pkg::CMD_DIV, -7, 2 * RAW_ONE),
         open_row(fpa_pkg::CMD_DIV, RAW_MIN, 0),
         open_row(fpa_pkg::CMD_MIN, -5, -5),
         open_row(fpa_pkg::CMD_MAX, 7, -7)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table with both sides idling
      foreach (directed_rows[i]) begin
         want = directed_rows[i].known ? directed_rows[i].want
                : fixed_point_op(directed_rows[i].command, directed_rows[i].a,
                                 directed_rows[i].b);
         send_item(directed_rows[i].command, directed_rows[i].a, directed_rows[i].b, want);
      end

      // Random traffic: swap the idle rates a third of the way in, then stop idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 62;
            receiver_idle_pct = 35;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         pick    = $urandom_range(0, 19);
         command = (pick < 18) ? CMD_BITS'(pick % 6) : CMD_BITS'(6 + pick - 18);
         a       = pick_operand();
         b       = ($urandom_range(0, 9) == 0) ? a : pick_operand();
         send_item(command, a, b, fixed_point_op(command, a, b));
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
